### rtl/core/acbm_pkg.sv
// ============================================================================
// acbm_pkg
// Shared constants, codes and types of the audio channel buffer manager.
// ============================================================================
`default_nettype none

package acbm_pkg;

    // Table geometry.
    localparam int CLIENT_SLOTS     = 8;
    localparam int BUFFERS_PER_SLOT = 4;
    localparam int RESULT_CAP       = 32;

    localparam int SLOT_W  = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;
    localparam int BUF_W   = (BUFFERS_PER_SLOT > 1) ? $clog2(BUFFERS_PER_SLOT) : 1;
    localparam int CNT_W   = $clog2(BUFFERS_PER_SLOT + 1);
    localparam int BDEPTH  = CLIENT_SLOTS * BUFFERS_PER_SLOT;
    localparam int BADDR_W = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
    localparam int RES_W   = $clog2(RESULT_CAP + 1);

    // Command codes.
    localparam logic [3:0] MODE_OPEN      = 4'd0;
    localparam logic [3:0] MODE_CLOSE     = 4'd1;
    localparam logic [3:0] MODE_ALLOC     = 4'd2;
    localparam logic [3:0] MODE_START     = 4'd3;
    localparam logic [3:0] MODE_STOP      = 4'd4;
    localparam logic [3:0] MODE_QUEUE     = 4'd5;
    localparam logic [3:0] MODE_SETPARAMS = 4'd6;
    localparam logic [3:0] MODE_MIXSELECT = 4'd7;
    localparam logic [3:0] MODE_RELEASE   = 4'd8;

    // Status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_INVALID  = 2'd2;

    // Buffer states.
    localparam logic [1:0] BS_READY  = 2'd0;
    localparam logic [1:0] BS_QUEUED = 2'd1;
    localparam logic [1:0] BS_BUSY   = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIND,
        S_APPLY,
        S_FILL,
        S_REPLY,
        S_SLOT,
        S_BRD,
        S_BCHK,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic [3:0]        mode;
        logic [31:0]       task_id;
        logic [7:0]        buf_count;
        logic signed [7:0] buf_id;
        logic              map_ok;
        logic              has_callback;
    } t_cmd;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] granted;
        logic       has_entry;
        logic [2:0] slot;
        logic [1:0] idx;
        logic       notify;
        logic       last;
    } t_result;

    // Update request to the slot flag registers.
    typedef struct packed {
        logic              open_en;
        logic              close_en;
        logic              play_en;
        logic              play_val;
        logic              count_en;
        logic [CNT_W-1:0]  count_val;
        logic              callback;
        logic [SLOT_W-1:0] slot;
        logic [SLOT_W-1:0] sel;
    } t_flag_cmd;

    // Flag view returned to the sequencer.
    typedef struct packed {
        logic [CLIENT_SLOTS-1:0] active;
        logic [CLIENT_SLOTS-1:0] playing;
        logic [CNT_W-1:0]        sel_count;
        logic                    sel_callback;
    } t_flag_view;

    function automatic logic [2:0] fit_slot(input logic [SLOT_W-1:0] s);
        logic [SLOT_W+2:0] w;
        w = {3'b000, s};
        return w[2:0];
    endfunction

    function automatic logic [1:0] fit_idx(input logic [BUF_W-1:0] b);
        logic [BUF_W+1:0] w;
        w = {2'b00, b};
        return w[1:0];
    endfunction

endpackage

`default_nettype wire

### rtl/core/acbm_ram.sv
// ============================================================================
// acbm_ram
// Simple dual-port synchronous RAM with a registered read port.
// ============================================================================
`default_nettype none

module acbm_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 32
) (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_waddr,
    input  wire logic [WIDTH-1:0]                              i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_raddr,
    output logic      [WIDTH-1:0]                              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### rtl/core/acbm_slot_flags.sv
// ============================================================================
// acbm_slot_flags
// Per-slot active, playing, buffer count and callback registers.
// ============================================================================
`default_nettype none

module acbm_slot_flags (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire acbm_pkg::t_flag_cmd    i_cmd,
    output acbm_pkg::t_flag_view        o_view
);
    import acbm_pkg::*;

    logic [CLIENT_SLOTS-1:0] r_active;
    logic [CLIENT_SLOTS-1:0] r_playing;
    logic [CNT_W-1:0]        r_count [CLIENT_SLOTS];
    logic [CLIENT_SLOTS-1:0] r_callback;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= '0;
            r_playing <= '0;
            for (int i = 0; i < CLIENT_SLOTS; i++) begin
                r_count[i] <= '0;
            end
        end else begin
            if (i_cmd.open_en) begin
                r_active[i_cmd.slot]  <= 1'b1;
                r_playing[i_cmd.slot] <= 1'b0;
                r_count[i_cmd.slot]   <= '0;
            end
            if (i_cmd.close_en) begin
                r_active[i_cmd.slot] <= 1'b0;
            end
            if (i_cmd.play_en) begin
                r_playing[i_cmd.slot] <= i_cmd.play_val;
            end
            if (i_cmd.count_en) begin
                r_count[i_cmd.slot] <= i_cmd.count_val;
            end
        end
    end

    // The callback flag is only read for active slots, so it needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.open_en) begin
            r_callback[i_cmd.slot] <= i_cmd.callback;
        end
    end

    always_comb begin
        o_view.active       = r_active;
        o_view.playing      = r_playing;
        o_view.sel_count    = r_count[i_cmd.sel];
        o_view.sel_callback = r_callback[i_cmd.sel];
    end

endmodule

`default_nettype wire

### rtl/core/acbm_seq.sv
// ============================================================================
// acbm_seq
// Command sequencer: task tag lookup, buffer state read-modify-write and
// result ordering through a one-deep pending register.
// ============================================================================
`default_nettype none

module acbm_seq (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire acbm_pkg::t_cmd       i_cmd,
    input  wire logic                 i_out_free,
    output logic                      o_push,
    output acbm_pkg::t_result         o_push_data,
    output acbm_pkg::t_flag_cmd       o_flag_cmd,
    input  wire acbm_pkg::t_flag_view i_flags
);
    import acbm_pkg::*;

    t_state            r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [CNT_W-1:0]  r_buf, n_buf;
    logic              r_found, n_found;
    logic [1:0]        r_status, n_status;
    logic [7:0]        r_granted, n_granted;
    logic [RES_W-1:0]  r_nres, n_nres;
    t_result           r_pend, n_pend;
    logic              r_pend_valid, n_pend_valid;

    logic               task_we;
    logic [SLOT_W-1:0]  task_waddr;
    logic [SLOT_W-1:0]  task_raddr;
    logic [31:0]        task_rdata;
    logic               buf_we;
    logic [BADDR_W-1:0] buf_waddr;
    logic [1:0]         buf_wdata;
    logic [BADDR_W-1:0] buf_raddr;
    logic [1:0]         buf_rdata;

    logic [SLOT_W-1:0] free_idx;
    logic              any_free;
    logic              last_slot;
    logic              is_rel;
    logic              elig;
    logic              hit;
    logic              more_bufs;
    logic [CNT_W-1:0]  clamp;
    t_result           res;

    function automatic logic [BADDR_W-1:0] baddr(input logic [SLOT_W-1:0] s,
                                                  input logic [BUF_W-1:0]  b);
        return BADDR_W'(BADDR_W'(s) * BADDR_W'(BUFFERS_PER_SLOT)) + BADDR_W'(b);
    endfunction

    acbm_ram #(.DEPTH(CLIENT_SLOTS), .WIDTH(32)) u_task_ram (
        .i_clk   (i_clk),
        .i_we    (task_we),
        .i_waddr (task_waddr),
        .i_wdata (r_cmd.task_id),
        .i_raddr (task_raddr),
        .o_rdata (task_rdata)
    );

    acbm_ram #(.DEPTH(BDEPTH), .WIDTH(2)) u_buf_ram (
        .i_clk   (i_clk),
        .i_we    (buf_we),
        .i_waddr (buf_waddr),
        .i_wdata (buf_wdata),
        .i_raddr (buf_raddr),
        .o_rdata (buf_rdata)
    );

    always_comb begin
        free_idx = '0;
        for (int i = CLIENT_SLOTS - 1; i >= 0; i--) begin
            if (!i_flags.active[i]) begin
                free_idx = SLOT_W'(i);
            end
        end
    end

    assign any_free   = ~&i_flags.active;
    assign last_slot  = (r_slot == SLOT_W'(CLIENT_SLOTS - 1));
    assign is_rel     = (r_cmd.mode == MODE_RELEASE);
    assign elig       = i_flags.active[r_slot] && (is_rel || i_flags.playing[r_slot])
                        && (i_flags.sel_count != '0);
    assign hit        = is_rel ? (buf_rdata == BS_BUSY) : (buf_rdata == BS_QUEUED);
    assign more_bufs  = (CNT_W'(r_buf + CNT_W'(1)) < i_flags.sel_count);
    assign clamp      = (r_cmd.buf_count > 8'(BUFFERS_PER_SLOT)) ?
                        CNT_W'(BUFFERS_PER_SLOT) : r_cmd.buf_count[CNT_W-1:0];
    assign buf_raddr  = baddr(r_slot, r_buf[BUF_W-1:0]);
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        res           = '0;
        res.has_entry = 1'b1;
        res.slot      = fit_slot(r_slot);
        res.idx       = fit_idx(r_buf[BUF_W-1:0]);
        res.notify    = is_rel && i_flags.sel_callback;
    end

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_slot       = r_slot;
        n_buf        = r_buf;
        n_found      = r_found;
        n_status     = r_status;
        n_granted    = r_granted;
        n_nres       = r_nres;
        n_pend       = r_pend;
        n_pend_valid = r_pend_valid;

        o_flag_cmd      = '0;
        o_flag_cmd.sel  = r_slot;
        o_flag_cmd.slot = r_slot;
        task_we    = 1'b0;
        task_waddr = free_idx;
        task_raddr = '0;
        buf_we     = 1'b0;
        buf_waddr  = buf_raddr;
        buf_wdata  = BS_READY;
        o_push      = 1'b0;
        o_push_data = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd        = i_cmd;
                    n_slot       = '0;
                    n_buf        = '0;
                    n_found      = 1'b0;
                    n_status     = ST_OK;
                    n_granted    = '0;
                    n_nres       = '0;
                    n_pend_valid = 1'b0;
                    case (i_cmd.mode)
                        MODE_CLOSE, MODE_ALLOC, MODE_START, MODE_STOP, MODE_QUEUE: begin
                            n_state = S_FIND;
                        end
                        MODE_MIXSELECT, MODE_RELEASE: begin
                            n_state = S_SLOT;
                        end
                        default: begin
                            n_state = S_APPLY;
                        end
                    endcase
                end
            end
            S_FIND: begin
                // The read data belongs to r_slot; the next slot is fetched meanwhile.
                task_raddr = SLOT_W'(r_slot + SLOT_W'(1));
                if (i_flags.active[r_slot] && task_rdata == r_cmd.task_id) begin
                    n_found = 1'b1;
                    n_state = S_APPLY;
                end else if (last_slot) begin
                    n_state = S_APPLY;
                end else begin
                    n_slot = SLOT_W'(r_slot + SLOT_W'(1));
                end
            end
            S_APPLY: begin
                n_state = S_REPLY;
                case (r_cmd.mode)
                    MODE_OPEN: begin
                        if (any_free) begin
                            o_flag_cmd.open_en  = 1'b1;
                            o_flag_cmd.slot     = free_idx;
                            o_flag_cmd.callback = r_cmd.has_callback;
                            task_we             = 1'b1;
                        end else begin
                            n_status = ST_NO_SPACE;
                        end
                    end
                    MODE_CLOSE: begin
                        o_flag_cmd.close_en = r_found;
                    end
                    MODE_ALLOC: begin
                        if (!r_found) begin
                            n_granted = r_cmd.buf_count;
                        end else if (r_cmd.map_ok) begin
                            o_flag_cmd.count_en  = 1'b1;
                            o_flag_cmd.count_val = clamp;
                            n_granted            = 8'(clamp);
                            n_buf                = '0;
                            if (clamp != '0) begin
                                n_state = S_FILL;
                            end
                        end
                    end
                    MODE_START, MODE_STOP: begin
                        o_flag_cmd.play_en  = r_found;
                        o_flag_cmd.play_val = (r_cmd.mode == MODE_START);
                    end
                    MODE_QUEUE: begin
                        if (r_found && !r_cmd.buf_id[7]
                            && {1'b0, r_cmd.buf_id[6:0]} < 8'(i_flags.sel_count)) begin
                            buf_we    = 1'b1;
                            buf_waddr = baddr(r_slot, r_cmd.buf_id[BUF_W-1:0]);
                            buf_wdata = BS_QUEUED;
                        end
                    end
                    MODE_SETPARAMS: begin
                        n_status = ST_OK;
                    end
                    default: begin
                        n_status = ST_INVALID;
                    end
                endcase
            end
            S_FILL: begin
                buf_we    = 1'b1;
                buf_wdata = BS_READY;
                n_buf     = CNT_W'(r_buf + CNT_W'(1));
                if (8'(r_buf) + 8'd1 == r_granted) begin
                    n_state = S_REPLY;
                end
            end
            S_REPLY: begin
                o_push              = 1'b1;
                o_push_data.status  = r_status;
                o_push_data.granted = r_granted;
                o_push_data.last    = 1'b1;
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_SLOT: begin
                n_buf = '0;
                if (elig) begin
                    n_state = S_BRD;
                end else if (last_slot) begin
                    n_state = S_FLUSH;
                end else begin
                    n_slot = SLOT_W'(r_slot + SLOT_W'(1));
                end
            end
            S_BRD: begin
                if (r_nres >= RES_W'(RESULT_CAP)) begin
                    n_state = S_FLUSH;
                end else begin
                    n_state = S_BCHK;
                end
            end
            S_BCHK: begin
                // A hit with a pending result waits until that result can move out.
                if (!(hit && r_pend_valid && !i_out_free)) begin
                    if (hit) begin
                        buf_we    = 1'b1;
                        buf_wdata = is_rel ? BS_READY : BS_BUSY;
                        if (r_pend_valid) begin
                            o_push      = 1'b1;
                            o_push_data = r_pend;
                        end
                        n_pend       = res;
                        n_pend_valid = 1'b1;
                        n_nres       = RES_W'(r_nres + RES_W'(1));
                    end
                    if ((hit && !is_rel) || !more_bufs) begin
                        if (last_slot) begin
                            n_state = S_FLUSH;
                        end else begin
                            n_slot  = SLOT_W'(r_slot + SLOT_W'(1));
                            n_state = S_SLOT;
                        end
                    end else begin
                        n_buf   = CNT_W'(r_buf + CNT_W'(1));
                        n_state = S_BRD;
                    end
                end
            end
            S_FLUSH: begin
                o_push = 1'b1;
                if (r_pend_valid) begin
                    o_push_data = r_pend;
                end
                o_push_data.last = 1'b1;
                if (i_out_free) begin
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pend_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_slot    <= n_slot;
        r_buf     <= n_buf;
        r_found   <= n_found;
        r_status  <= n_status;
        r_granted <= n_granted;
        r_nres    <= n_nres;
        r_pend    <= n_pend;
    end

    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !r_pend_valid)
        else $error("pending result left over when a new command may enter");

    a_push_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && !i_out_free) |=> (r_state == $past(r_state)))
        else $error("sequencer moved on while its result was refused");

    a_read_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BCHK) |-> ($past(r_state) == S_BRD || $past(r_state) == S_BCHK))
        else $error("buffer state checked without a read issued the cycle before");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second command accepted before the first finished");

endmodule

`default_nettype wire

### rtl/core/audio_channel_buffer_manager.sv
// ============================================================================
// audio_channel_buffer_manager
// Playback client slot table with per-buffer ready, queued and busy states.
// ============================================================================
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+------------------------------
//  command | in        | i_in_valid / o_in_ready  | mode, task_id, buf_count,
//          |           |                          | buf_id, map_ok, has_callback
//  result  | out       | o_out_valid / i_out_ready| status, granted_count,
//          |           |                          | has_entry, client_slot,
//          |           |                          | buf_index, notify, last
//
// One command is processed at a time. Open, set-params and invalid commands
// go from S_APPLY straight to S_REPLY. Close, alloc, start, stop and queue
// scan the task tag RAM one slot per cycle, up to CLIENT_SLOTS slots, and
// alloc then sets the state of each granted buffer to ready. Mix-select and
// release walk the slots; each buffer examined passes through a read state
// and a check state, as the buffer state RAM has a registered read port.
// Reset clears the active, playing and count flags at once; there is no
// clearing pass. A stalled result output only halts the sequencer when a further result must be moved.
//
`default_nettype none

module audio_channel_buffer_manager (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [3:0]  i_mode,
    input  wire logic [31:0] i_task_id,
    input  wire logic [7:0]  i_buf_count,
    input  wire logic signed [7:0] i_buf_id,
    input  wire logic        i_map_ok,
    input  wire logic        i_has_callback,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_status,
    output logic [7:0]       o_granted_count,
    output logic             o_has_entry,
    output logic [2:0]       o_client_slot,
    output logic [1:0]       o_buf_index,
    output logic             o_notify,
    output logic             o_last
);
    import acbm_pkg::*;

    t_cmd       cmd;
    t_result    push_data;
    logic       push;
    logic       out_free;
    t_flag_cmd  flag_cmd;
    t_flag_view flag_view;

    // The output register frees up in the same cycle its transfer completes,
    // so the sequencer can hand over the next result without a bubble.
    logic    r_out_valid;
    t_result r_out;

    always_comb begin
        cmd.mode         = i_mode;
        cmd.task_id      = i_task_id;
        cmd.buf_count    = i_buf_count;
        cmd.buf_id       = i_buf_id;
        cmd.map_ok       = i_map_ok;
        cmd.has_callback = i_has_callback;
    end

    assign out_free = !r_out_valid || i_out_ready;

    acbm_slot_flags u_flags (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (flag_cmd),
        .o_view  (flag_view)
    );

    acbm_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd       (cmd),
        .i_out_free  (out_free),
        .o_push      (push),
        .o_push_data (push_data),
        .o_flag_cmd  (flag_cmd),
        .i_flags     (flag_view)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push && out_free) begin
            r_out <= push_data;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out.status;
    assign o_granted_count = r_out.granted;
    assign o_has_entry     = r_out.has_entry;
    assign o_client_slot   = r_out.slot;
    assign o_buf_index     = r_out.idx;
    assign o_notify        = r_out.notify;
    assign o_last          = r_out.last;

endmodule

`default_nettype wire
